// ===== rtl/sfts_pkg.sv =====
// Shared types, codes and helpers for the SPI flash transfer sequencer.
// Used by every module under rtl/; depends on nothing.
package sfts_pkg;

    localparam int DEVICE_COUNT_DEF = 64;
    localparam int MAX_TRANSFER     = 4096;

    localparam int DEV_W    = 6;
    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 13;
    localparam int OFF_W    = 12;
    localparam int ABYTES_W = 3;
    localparam int MASK_W   = 64;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 80;

    // operation codes on the input stream
    localparam logic [2:0] OP_START_READ  = 3'd0;
    localparam logic [2:0] OP_START_WRITE = 3'd1;
    localparam logic [2:0] OP_START_ERASE = 3'd2;
    localparam logic [2:0] OP_XFER_DONE   = 3'd3;
    localparam logic [2:0] OP_STATUS      = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_ADDR_BYTES  = 2'd0;
    localparam logic [1:0] CFG_PAGE_SIZE   = 2'd1;
    localparam logic [1:0] CFG_DEVICE_SIZE = 2'd2;
    localparam logic [1:0] CFG_DEVICE_MASK = 2'd3;

    // error codes
    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_BAD_ARG = 2'd1;
    localparam logic [1:0] ERR_BAD_CFG = 2'd2;

    // SPI command bytes
    localparam logic [7:0] SPI_RD_DATA = 8'h03;
    localparam logic [7:0] SPI_RDSR    = 8'h05;
    localparam logic [7:0] SPI_PROG    = 8'h02;
    localparam logic [7:0] SPI_WREN    = 8'h06;
    localparam logic [7:0] SPI_ERASE   = 8'hD8;
    localparam logic [7:0] SPI_NONE    = 8'h00;

    localparam logic [1:0] OPK_READ  = 2'd0;
    localparam logic [1:0] OPK_WRITE = 2'd1;
    localparam logic [1:0] OPK_ERASE = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_READ = 3'd1,
        PH_WREN = 3'd2,
        PH_CMD  = 3'd3,
        PH_POLL = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        KIND_DONE  = 3'd0,
        KIND_WREN  = 3'd1,
        KIND_READ  = 3'd2,
        KIND_PROG  = 3'd3,
        KIND_ERASE = 3'd4,
        KIND_RDSR  = 3'd5,
        KIND_ERROR = 3'd6
    } kind_t;

    typedef struct packed {
        logic [ABYTES_W-1:0] addr_bytes;
        logic [LEN_W-1:0]    page_size;
        logic [ADDR_W-1:0]   device_size;
    } cfg_t;

    typedef struct packed {
        logic [2:0]        operation;
        logic [DEV_W-1:0]  device;
        logic [ADDR_W-1:0] start_address;
        logic [LEN_W-1:0]  length;
        logic [7:0]        status_byte;
    } item_t;

    typedef struct packed {
        kind_t               kind;
        logic [DEV_W-1:0]    chip_select;
        logic [7:0]          opcode;
        logic [ADDR_W-1:0]   flash_address;
        logic [ABYTES_W-1:0] address_count;
        logic [LEN_W-1:0]    data_length;
        logic [OFF_W-1:0]    data_offset;
        logic [1:0]          error_code;
    } result_t;

    // bytes up to the next page boundary, capped by what is left
    function automatic logic [LEN_W-1:0] next_chunk(
        input logic [ADDR_W-1:0] addr,
        input logic [LEN_W-1:0]  left,
        input logic [LEN_W-1:0]  pg
    );
        logic [ADDR_W-1:0] pg32;
        logic [ADDR_W-1:0] span;
        pg32 = ADDR_W'(pg);
        span = pg32 - (addr & (pg32 - ADDR_W'(1)));
        return (ADDR_W'(left) < span) ? left : span[LEN_W-1:0];
    endfunction

endpackage

// ===== rtl/sfts_cfg.sv =====
// Configuration registers of the SPI flash transfer sequencer.
// Depends on sfts_pkg.
module sfts_cfg #(
    parameter int DEVICE_COUNT = sfts_pkg::DEVICE_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [sfts_pkg::MASK_W-1:0]    cfg_data,
    output sfts_pkg::cfg_t                 cfg,
    output logic [DEVICE_COUNT-1:0]        dev_mask
);

    sfts_pkg::cfg_t          cfg_reg;
    logic [DEVICE_COUNT-1:0] mask_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;
    assign dev_mask  = mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg  <= '0;
            mask_reg <= DEVICE_COUNT'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sfts_pkg::CFG_ADDR_BYTES:
                    cfg_reg.addr_bytes <= cfg_data[sfts_pkg::ABYTES_W-1:0];
                sfts_pkg::CFG_PAGE_SIZE:
                    cfg_reg.page_size <= cfg_data[sfts_pkg::LEN_W-1:0];
                sfts_pkg::CFG_DEVICE_SIZE:
                    cfg_reg.device_size <= cfg_data[sfts_pkg::ADDR_W-1:0];
                sfts_pkg::CFG_DEVICE_MASK:
                    mask_reg <= cfg_data[DEVICE_COUNT-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

// ===== rtl/sfts_in_stage.sv =====
// Input register of the sequencer: holds one request or event.
// Depends on sfts_pkg.
module sfts_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sfts_pkg::item_t in_item,
    input  logic            take,
    output logic            item_valid,
    output sfts_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    sfts_pkg::item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_item;
    end

endmodule

// ===== rtl/sfts_seq.sv =====
// Transfer state and one-pass descriptor logic: start checks, page split,
// write enable / program / status poll sequencing. Depends on sfts_pkg.
module sfts_seq #(
    parameter int DEVICE_COUNT = sfts_pkg::DEVICE_COUNT_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    go,
    input  sfts_pkg::item_t         item,
    input  sfts_pkg::cfg_t          cfg,
    input  logic [DEVICE_COUNT-1:0] dev_mask,
    output logic                    res_valid,
    output sfts_pkg::result_t       res
);

    sfts_pkg::phase_t                 phase_reg, phase_next;
    logic [1:0]                       op_kind_reg, op_kind_next;
    logic [sfts_pkg::DEV_W-1:0]       target_reg, target_next;
    logic [sfts_pkg::ADDR_W-1:0]      addr_reg, addr_next;
    logic [sfts_pkg::LEN_W-1:0]       left_reg, left_next;
    logic [sfts_pkg::LEN_W-1:0]       chunk_reg, chunk_next;
    logic [sfts_pkg::OFF_W-1:0]       off_reg, off_next;

    logic [sfts_pkg::ADDR_W-1:0]      adv_addr;
    logic [sfts_pkg::OFF_W-1:0]       adv_off;
    logic [sfts_pkg::LEN_W-1:0]       adv_left;
    logic [sfts_pkg::ADDR_W-1:0]      chk_addr;
    logic [sfts_pkg::LEN_W-1:0]       chk_left;
    logic [sfts_pkg::LEN_W-1:0]       chunk;
    logic [sfts_pkg::MASK_W-1:0]      mask_ext;
    logic                             is_start;
    logic                             is_erase;
    logic                             is_done;
    logic                             is_status;
    logic                             dev_ok;
    logic                             cfg_bad;
    logic                             arg_bad;
    logic                             addr_wide;
    logic                             busy;

    // advance, start checks and chunk size
    always_comb
    begin
        adv_addr  = addr_reg + sfts_pkg::ADDR_W'(chunk_reg);
        adv_off   = off_reg + chunk_reg[sfts_pkg::OFF_W-1:0];
        adv_left  = (chunk_reg <= left_reg) ? left_reg - chunk_reg : '0;

        is_start  = item.operation <= sfts_pkg::OP_START_ERASE;
        is_erase  = item.operation == sfts_pkg::OP_START_ERASE;
        is_done   = item.operation == sfts_pkg::OP_XFER_DONE;
        is_status = item.operation == sfts_pkg::OP_STATUS;
        busy      = item.status_byte[0];

        mask_ext  = sfts_pkg::MASK_W'(dev_mask);
        dev_ok    = mask_ext[item.device];

        cfg_bad = (cfg.addr_bytes == '0) || (cfg.addr_bytes > 3'd4) ||
                  (cfg.device_size == '0) ||
                  (!is_erase && ((cfg.page_size == '0) ||
                                 ((cfg.page_size & (cfg.page_size - 1'b1)) != '0) ||
                                 (cfg.page_size > sfts_pkg::LEN_W'(sfts_pkg::MAX_TRANSFER))));

        unique case (cfg.addr_bytes)
            3'd1:    addr_wide = item.start_address[31:8] != '0;
            3'd2:    addr_wide = item.start_address[31:16] != '0;
            3'd3:    addr_wide = item.start_address[31:24] != '0;
            default: addr_wide = 1'b0;
        endcase

        arg_bad = addr_wide ||
                  (is_erase && (item.start_address >= cfg.device_size)) ||
                  (!is_erase &&
                   ((item.length == '0) ||
                    (item.length > sfts_pkg::LEN_W'(sfts_pkg::MAX_TRANSFER)) ||
                    (sfts_pkg::ADDR_W'(item.length) > cfg.device_size) ||
                    (item.start_address >
                     cfg.device_size - sfts_pkg::ADDR_W'(item.length))));

        priority if (phase_reg == sfts_pkg::PH_IDLE)
        begin
            chk_addr = item.start_address;
            chk_left = item.length;
        end
        else if (phase_reg == sfts_pkg::PH_READ)
        begin
            chk_addr = adv_addr;
            chk_left = adv_left;
        end
        else
        begin
            chk_addr = addr_reg;
            chk_left = left_reg;
        end
        chunk = sfts_pkg::next_chunk(chk_addr, chk_left, cfg.page_size);
    end

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        op_kind_next = op_kind_reg;
        target_next  = target_reg;
        addr_next    = addr_reg;
        left_next    = left_reg;
        chunk_next   = chunk_reg;
        off_next     = off_reg;
        unique case (phase_reg)
            sfts_pkg::PH_IDLE:
            begin
                if (go && is_start && dev_ok && !cfg_bad && !arg_bad)
                begin
                    op_kind_next = item.operation[1:0];
                    target_next  = item.device;
                    addr_next    = item.start_address;
                    left_next    = is_erase ? '0 : item.length;
                    off_next     = '0;
                    if (item.operation == sfts_pkg::OP_START_READ)
                    begin
                        phase_next = sfts_pkg::PH_READ;
                        chunk_next = chunk;
                    end
                    else
                    begin
                        phase_next = sfts_pkg::PH_WREN;
                        chunk_next = '0;
                    end
                end
            end
            sfts_pkg::PH_READ:
            begin
                if (go && is_done)
                begin
                    addr_next = adv_addr;
                    off_next  = adv_off;
                    left_next = adv_left;
                    if (adv_left == '0)
                    begin
                        phase_next = sfts_pkg::PH_IDLE;
                        chunk_next = '0;
                    end
                    else
                        chunk_next = chunk;
                end
            end
            sfts_pkg::PH_WREN:
            begin
                if (go && is_done)
                begin
                    phase_next = sfts_pkg::PH_CMD;
                    if (op_kind_reg != sfts_pkg::OPK_ERASE)
                        chunk_next = chunk;
                end
            end
            sfts_pkg::PH_CMD:
            begin
                if (go && is_done)
                    phase_next = sfts_pkg::PH_POLL;
            end
            sfts_pkg::PH_POLL:
            begin
                if (go && is_status && !busy)
                begin
                    addr_next  = adv_addr;
                    off_next   = adv_off;
                    left_next  = adv_left;
                    chunk_next = '0;
                    if (op_kind_reg == sfts_pkg::OPK_WRITE && adv_left != '0)
                        phase_next = sfts_pkg::PH_WREN;
                    else
                        phase_next = sfts_pkg::PH_IDLE;
                end
            end
            default:
                phase_next = sfts_pkg::PH_IDLE;
        endcase
    end

    // descriptor
    always_comb
    begin
        res_valid         = 1'b0;
        res               = '0;
        res.kind          = sfts_pkg::KIND_DONE;
        res.chip_select   = target_reg;
        unique case (phase_reg)
            sfts_pkg::PH_IDLE:
            begin
                res_valid       = go && is_start;
                res.chip_select = item.device;
                priority if (!dev_ok)
                begin
                    res.kind       = sfts_pkg::KIND_ERROR;
                    res.error_code = sfts_pkg::ERR_BAD_ARG;
                end
                else if (cfg_bad)
                begin
                    res.kind       = sfts_pkg::KIND_ERROR;
                    res.error_code = sfts_pkg::ERR_BAD_CFG;
                end
                else if (arg_bad)
                begin
                    res.kind       = sfts_pkg::KIND_ERROR;
                    res.error_code = sfts_pkg::ERR_BAD_ARG;
                end
                else if (item.operation == sfts_pkg::OP_START_READ)
                begin
                    res.kind          = sfts_pkg::KIND_READ;
                    res.opcode        = sfts_pkg::SPI_RD_DATA;
                    res.flash_address = item.start_address;
                    res.address_count = cfg.addr_bytes;
                    res.data_length   = chunk;
                end
                else
                begin
                    res.kind   = sfts_pkg::KIND_WREN;
                    res.opcode = sfts_pkg::SPI_WREN;
                end
            end
            sfts_pkg::PH_READ:
            begin
                res_valid = go && is_done;
                if (adv_left != '0)
                begin
                    res.kind          = sfts_pkg::KIND_READ;
                    res.opcode        = sfts_pkg::SPI_RD_DATA;
                    res.flash_address = adv_addr;
                    res.address_count = cfg.addr_bytes;
                    res.data_length   = chunk;
                    res.data_offset   = adv_off;
                end
            end
            sfts_pkg::PH_WREN:
            begin
                res_valid         = go && is_done;
                res.flash_address = addr_reg;
                res.address_count = cfg.addr_bytes;
                if (op_kind_reg == sfts_pkg::OPK_ERASE)
                begin
                    res.kind   = sfts_pkg::KIND_ERASE;
                    res.opcode = sfts_pkg::SPI_ERASE;
                end
                else
                begin
                    res.kind        = sfts_pkg::KIND_PROG;
                    res.opcode      = sfts_pkg::SPI_PROG;
                    res.data_length = chunk;
                    res.data_offset = off_reg;
                end
            end
            sfts_pkg::PH_CMD:
            begin
                res_valid       = go && is_done;
                res.kind        = sfts_pkg::KIND_RDSR;
                res.opcode      = sfts_pkg::SPI_RDSR;
                res.data_length = sfts_pkg::LEN_W'(1);
            end
            sfts_pkg::PH_POLL:
            begin
                res_valid = go && is_status;
                priority if (busy)
                begin
                    res.kind        = sfts_pkg::KIND_RDSR;
                    res.opcode      = sfts_pkg::SPI_RDSR;
                    res.data_length = sfts_pkg::LEN_W'(1);
                end
                else if (op_kind_reg == sfts_pkg::OPK_WRITE && adv_left != '0)
                begin
                    res.kind   = sfts_pkg::KIND_WREN;
                    res.opcode = sfts_pkg::SPI_WREN;
                end
                else
                    res.kind = sfts_pkg::KIND_DONE;
            end
            default:
                res_valid = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= sfts_pkg::PH_IDLE;
            op_kind_reg <= '0;
            target_reg  <= '0;
            addr_reg    <= '0;
            left_reg    <= '0;
            chunk_reg   <= '0;
            off_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            op_kind_reg <= op_kind_next;
            target_reg  <= target_next;
            addr_reg    <= addr_next;
            left_reg    <= left_next;
            chunk_reg   <= chunk_next;
            off_reg     <= off_next;
        end
    end

    a_read_kind: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == sfts_pkg::PH_READ |-> op_kind_reg == sfts_pkg::OPK_READ)
        else $error("read phase with non-read transfer");

    a_erase_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != sfts_pkg::PH_IDLE && op_kind_reg == sfts_pkg::OPK_ERASE)
        |-> left_reg == '0)
        else $error("erase carries a byte count");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == sfts_pkg::KIND_DONE) |=> phase_reg == sfts_pkg::PH_IDLE)
        else $error("done descriptor without return to idle");

    a_error_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == sfts_pkg::KIND_ERROR) |=> phase_reg == sfts_pkg::PH_IDLE)
        else $error("rejected request left the sequencer busy");

endmodule

// ===== rtl/sfts_out_stage.sv =====
// Result register: holds one descriptor until the consumer takes it.
// Depends on sfts_pkg.
module sfts_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  sfts_pkg::result_t res,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output sfts_pkg::result_t out_res
);

    logic              valid_reg;
    logic              valid_next;
    sfts_pkg::result_t res_reg;

    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

endmodule

// ===== rtl/spi_flash_transfer_sequencer_unit.sv =====
// Top level of the SPI flash transfer sequencer.
// Depends on sfts_pkg, sfts_cfg, sfts_in_stage, sfts_seq, sfts_out_stage.
//
//   channel   direction  payload
//   s_axis    in         tuser: operation; tdata: device, start_address, length, status_byte
//   m_axis    out        tuser: kind; tdata: chip_select .. error_code
//   cfg       in         cfg_index, cfg_data (write only)
//
// An event is registered, then decoded combinationally into at most one
// descriptor that lands in the result register.
// One event per cycle is accepted while the result register is free or drained.
// Reset empties both registers, the sequencer goes idle, device_mask reads 1.
// A stall on m_axis backs up through the input register to s_axis_tready.
module spi_flash_transfer_sequencer_unit #(
    parameter int DEVICE_COUNT = sfts_pkg::DEVICE_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [5:0] device, [37:6] start_address, [50:38] length, [58:51] status_byte
    input  logic [sfts_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [2:0] operation
    input  logic [2:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [5:0] chip_select, [13:6] opcode, [45:14] flash_address, [48:46] address_count,
    // [61:49] data_length, [73:62] data_offset, [75:74] error_code
    output logic [sfts_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // [2:0] kind
    output logic [2:0]                       m_axis_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [sfts_pkg::MASK_W-1:0]      cfg_data
);

    sfts_pkg::cfg_t          cfg;
    logic [DEVICE_COUNT-1:0] dev_mask;
    sfts_pkg::item_t         in_item;
    sfts_pkg::item_t         item;
    logic                    item_valid;
    logic                    go;
    logic                    out_free;
    logic                    res_valid;
    sfts_pkg::result_t       res;
    sfts_pkg::result_t       out_res;

    assign in_item.operation     = s_axis_tuser;
    assign in_item.device        = s_axis_tdata[5:0];
    assign in_item.start_address = s_axis_tdata[37:6];
    assign in_item.length        = s_axis_tdata[50:38];
    assign in_item.status_byte   = s_axis_tdata[58:51];

    assign go = item_valid && out_free;

    sfts_cfg #(
        .DEVICE_COUNT(DEVICE_COUNT)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cfg      (cfg),
        .dev_mask (dev_mask)
    );

    sfts_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .take      (go),
        .item_valid(item_valid),
        .item      (item)
    );

    sfts_seq #(
        .DEVICE_COUNT(DEVICE_COUNT)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .item     (item),
        .cfg      (cfg),
        .dev_mask (dev_mask),
        .res_valid(res_valid),
        .res      (res)
    );

    sfts_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_valid),
        .res      (res),
        .free     (out_free),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_res  (out_res)
    );

    assign m_axis_tuser = out_res.kind;
    assign m_axis_tdata = {4'b0000,
                           out_res.error_code,
                           out_res.data_offset,
                           out_res.data_length,
                           out_res.address_count,
                           out_res.flash_address,
                           out_res.opcode,
                           out_res.chip_select};

endmodule

// ===== test/spi_flash_transfer_sequencer_unit_tb.sv =====
// Testbench for spi_flash_transfer_sequencer_unit: drives requests and flash replies on
// s_axis, register writes on cfg, and checks every m_axis descriptor against a predictor.
// Depends on rtl/sfts_pkg.sv and the RTL of the unit.
module spi_flash_transfer_sequencer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;

    // unused operation codes, must be dropped
    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;

    class descriptor_scoreboard;
        logic [2:0]          addr_bytes;
        logic [12:0]         page_size;
        logic [31:0]         device_size;
        logic [63:0]         device_mask;
        sfts_pkg::phase_t    phase;
        logic [1:0]          op_kind;
        logic [5:0]          target;
        logic [31:0]         next_addr;
        logic [12:0]         bytes_left;
        logic [12:0]         chunk_len;
        logic [11:0]         buf_off;
        sfts_pkg::result_t   expected_q[$];
        int                  errors;

        function new();
            addr_bytes  = 3'd0;
            page_size   = 13'd0;
            device_size = 32'd0;
            device_mask = 64'd1;
            phase       = sfts_pkg::PH_IDLE;
            op_kind     = sfts_pkg::OPK_READ;
            target      = 6'd0;
            next_addr   = 32'd0;
            bytes_left  = 13'd0;
            chunk_len   = 13'd0;
            buf_off     = 12'd0;
            errors      = 0;
        endfunction

        function void write_register(logic [1:0] idx, logic [63:0] val);
            case (idx)
                sfts_pkg::CFG_ADDR_BYTES:  addr_bytes = val[2:0];
                sfts_pkg::CFG_PAGE_SIZE:   page_size = val[12:0];
                sfts_pkg::CFG_DEVICE_SIZE: device_size = val[31:0];
                sfts_pkg::CFG_DEVICE_MASK: device_mask = val;
                default: ;
            endcase
        endfunction

        function sfts_pkg::result_t desc(sfts_pkg::kind_t k, logic [5:0] cs, logic [7:0] opc,
                                         logic [31:0] a, logic [2:0] ac, logic [12:0] dl,
                                         logic [11:0] off, logic [1:0] err);
            sfts_pkg::result_t r;
            r.kind          = k;
            r.chip_select   = cs;
            r.opcode        = opc;
            r.flash_address = a;
            r.address_count = ac;
            r.data_length   = dl;
            r.data_offset   = off;
            r.error_code    = err;
            return r;
        endfunction

        function sfts_pkg::result_t simple(sfts_pkg::kind_t k, logic [7:0] opc,
                                           logic [12:0] dl);
            return desc(k, target, opc, 32'd0, 3'd0, dl, 12'd0, sfts_pkg::ERR_OK);
        endfunction

        // chunk stops at the next page boundary
        function sfts_pkg::result_t data_desc();
            logic [31:0] pg;
            logic [31:0] span;
            pg = {19'd0, page_size};
            span = pg - (next_addr & (pg - 32'd1));
            chunk_len = ({19'd0, bytes_left} < span) ? bytes_left : span[12:0];
            if (op_kind == sfts_pkg::OPK_READ)
                return desc(sfts_pkg::KIND_READ, target, sfts_pkg::SPI_RD_DATA, next_addr,
                            addr_bytes, chunk_len, buf_off, sfts_pkg::ERR_OK);
            return desc(sfts_pkg::KIND_PROG, target, sfts_pkg::SPI_PROG, next_addr,
                        addr_bytes, chunk_len, buf_off, sfts_pkg::ERR_OK);
        endfunction

        function void advance();
            next_addr  = next_addr + {19'd0, chunk_len};
            buf_off    = buf_off + chunk_len[11:0];
            bytes_left = (chunk_len <= bytes_left) ? bytes_left - chunk_len : 13'd0;
            chunk_len  = 13'd0;
        endfunction

        function sfts_pkg::result_t start(sfts_pkg::item_t it);
            logic        erase;
            logic [31:0] a;
            logic [12:0] n;
            erase = (it.operation == sfts_pkg::OP_START_ERASE);
            a = it.start_address;
            n = it.length;
            if (int'(it.device) >= sfts_pkg::DEVICE_COUNT_DEF || !device_mask[it.device])
                return desc(sfts_pkg::KIND_ERROR, it.device, sfts_pkg::SPI_NONE, 32'd0, 3'd0,
                            13'd0, 12'd0, sfts_pkg::ERR_BAD_ARG);
            if (addr_bytes == 0 || addr_bytes > 4 || device_size == 0 ||
                (!erase && (page_size == 0 || (page_size & (page_size - 13'd1)) != 0 ||
                            page_size > sfts_pkg::MAX_TRANSFER)))
                return desc(sfts_pkg::KIND_ERROR, it.device, sfts_pkg::SPI_NONE, 32'd0, 3'd0,
                            13'd0, 12'd0, sfts_pkg::ERR_BAD_CFG);
            if ((addr_bytes < 4 && {32'd0, a} >= (64'd1 << (8 * addr_bytes))) ||
                (erase && a >= device_size) ||
                (!erase && (n == 0 || n > sfts_pkg::MAX_TRANSFER ||
                            {19'd0, n} > device_size || a > device_size - {19'd0, n})))
                return desc(sfts_pkg::KIND_ERROR, it.device, sfts_pkg::SPI_NONE, 32'd0, 3'd0,
                            13'd0, 12'd0, sfts_pkg::ERR_BAD_ARG);
            op_kind    = it.operation[1:0];
            target     = it.device;
            next_addr  = a;
            bytes_left = erase ? 13'd0 : n;
            chunk_len  = 13'd0;
            buf_off    = 12'd0;
            if (it.operation == sfts_pkg::OP_START_READ)
            begin
                phase = sfts_pkg::PH_READ;
                return data_desc();
            end
            phase = sfts_pkg::PH_WREN;
            return simple(sfts_pkg::KIND_WREN, sfts_pkg::SPI_WREN, 13'd0);
        endfunction

        function void note_request(sfts_pkg::item_t it);
            sfts_pkg::result_t r;
            bit                produced;
            produced = 1'b1;
            if (it.operation <= sfts_pkg::OP_START_ERASE)
            begin
                if (phase == sfts_pkg::PH_IDLE)
                    r = start(it);
                else
                    produced = 1'b0;
            end
            else if (it.operation == sfts_pkg::OP_XFER_DONE && phase == sfts_pkg::PH_READ)
            begin
                advance();
                if (bytes_left == 0)
                begin
                    phase = sfts_pkg::PH_IDLE;
                    r = simple(sfts_pkg::KIND_DONE, sfts_pkg::SPI_NONE, 13'd0);
                end
                else
                    r = data_desc();
            end
            else if (it.operation == sfts_pkg::OP_XFER_DONE && phase == sfts_pkg::PH_WREN)
            begin
                phase = sfts_pkg::PH_CMD;
                if (op_kind == sfts_pkg::OPK_ERASE)
                    r = desc(sfts_pkg::KIND_ERASE, target, sfts_pkg::SPI_ERASE, next_addr,
                             addr_bytes, 13'd0, 12'd0, sfts_pkg::ERR_OK);
                else
                    r = data_desc();
            end
            else if (it.operation == sfts_pkg::OP_XFER_DONE && phase == sfts_pkg::PH_CMD)
            begin
                phase = sfts_pkg::PH_POLL;
                r = simple(sfts_pkg::KIND_RDSR, sfts_pkg::SPI_RDSR, 13'd1);
            end
            else if (it.operation == sfts_pkg::OP_STATUS && phase == sfts_pkg::PH_POLL)
            begin
                if (it.status_byte[0])
                    r = simple(sfts_pkg::KIND_RDSR, sfts_pkg::SPI_RDSR, 13'd1);
                else
                begin
                    advance();
                    if (op_kind == sfts_pkg::OPK_WRITE && bytes_left != 0)
                    begin
                        phase = sfts_pkg::PH_WREN;
                        r = simple(sfts_pkg::KIND_WREN, sfts_pkg::SPI_WREN, 13'd0);
                    end
                    else
                    begin
                        phase = sfts_pkg::PH_IDLE;
                        r = simple(sfts_pkg::KIND_DONE, sfts_pkg::SPI_NONE, 13'd0);
                    end
                end
            end
            else
                produced = 1'b0;
            if (produced)
                expected_q.push_back(r);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function string show(sfts_pkg::result_t r);
            return {$sformatf("kind %0d cs %0d opcode %02h addr %08h", r.kind,
                              r.chip_select, r.opcode, r.flash_address),
                    $sformatf(" acnt %0d len %0d off %0d err %0d", r.address_count,
                              r.data_length, r.data_offset, r.error_code)};
        endfunction

        function void check_descriptor(sfts_pkg::result_t got);
            sfts_pkg::result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: expected none, actual %s", $time, show(got));
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind || got.chip_select !== want.chip_select ||
                got.opcode !== want.opcode || got.flash_address !== want.flash_address ||
                got.address_count !== want.address_count ||
                got.data_length !== want.data_length ||
                got.data_offset !== want.data_offset || got.error_code !== want.error_code)
            begin
                errors++;
                $display("%0t: expected %s, actual %s", $time, show(want), show(got));
            end
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [sfts_pkg::IN_DATA_W-1:0]   s_axis_tdata;
    logic [2:0]                       s_axis_tuser;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [sfts_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
    logic [2:0]                       m_axis_tuser;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [1:0]                       cfg_index;
    logic [sfts_pkg::MASK_W-1:0]      cfg_data;

    descriptor_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int quiet_cycles;

    spi_flash_transfer_sequencer_unit dut (.*);

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        sfts_pkg::result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind          = sfts_pkg::kind_t'(m_axis_tuser);
            got.chip_select   = m_axis_tdata[5:0];
            got.opcode        = m_axis_tdata[13:6];
            got.flash_address = m_axis_tdata[45:14];
            got.address_count = m_axis_tdata[48:46];
            got.data_length   = m_axis_tdata[61:49];
            got.data_offset   = m_axis_tdata[73:62];
            got.error_code    = m_axis_tdata[75:74];
            sb.check_descriptor(got);
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready = 1'b0;
                hold_left--;
            end
            else
                m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(sfts_pkg::item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {5'd0, it.status_byte, it.length, it.start_address, it.device};
        s_axis_tuser  = it.operation;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_request(it);
    endtask

    task automatic issue(logic [2:0] op, logic [5:0] dev, logic [31:0] addr,
                         logic [12:0] len, logic [7:0] st);
        sfts_pkg::item_t it;
        it.operation     = op;
        it.device        = dev;
        it.start_address = addr;
        it.length        = len;
        it.status_byte   = st;
        send_item(it);
    endtask

    // wait until every descriptor is in and the pipeline has emptied
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_register(logic [1:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        sb.write_register(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic preset(logic [2:0] ab, logic [12:0] pg, logic [31:0] size,
                          logic [63:0] mask);
        settle();
        program_register(sfts_pkg::CFG_ADDR_BYTES, {61'd0, ab});
        program_register(sfts_pkg::CFG_PAGE_SIZE, {51'd0, pg});
        program_register(sfts_pkg::CFG_DEVICE_SIZE, {32'd0, size});
        program_register(sfts_pkg::CFG_DEVICE_MASK, mask);
    endtask

    task automatic retune();
        int r;
        settle();
        if ($urandom_range(99) < 60)
        begin
            r = $urandom_range(99);
            program_register(sfts_pkg::CFG_ADDR_BYTES,
                             (r < 80) ? 64'($urandom_range(4, 1)) :
                             (r < 90) ? 64'd0 : 64'($urandom_range(7, 5)));
        end
        if ($urandom_range(99) < 60)
        begin
            r = $urandom_range(99);
            program_register(sfts_pkg::CFG_PAGE_SIZE,
                             (r < 80) ? (64'd1 << $urandom_range(12, 0)) :
                             (r < 90) ? 64'd0 : {$urandom, $urandom});
        end
        if ($urandom_range(99) < 60)
        begin
            r = $urandom_range(99);
            program_register(sfts_pkg::CFG_DEVICE_SIZE,
                             (r < 40) ? 64'($urandom_range(32'h0100_0000, 1)) :
                             (r < 60) ? 64'hFFFF_FFFF :
                             (r < 75) ? 64'($urandom_range(8192, 1)) :
                             (r < 85) ? 64'd0 : {$urandom, $urandom});
        end
        if ($urandom_range(99) < 60)
        begin
            r = $urandom_range(99);
            program_register(sfts_pkg::CFG_DEVICE_MASK, (r < 50) ? '1 :
                             (r < 70) ? {$urandom, $urandom} :
                             (r < 80) ? (64'd1 << $urandom_range(63, 0)) :
                             (r < 90) ? 64'd0 : ~(64'd1 << $urandom_range(63, 0)));
        end
    endtask

    // mostly a well-formed next step for the current phase, some pure noise
    function automatic sfts_pkg::item_t pick_request(int noise_pct, int busy_pct);
        sfts_pkg::item_t it;
        logic [63:0]     lim;
        logic [31:0]     span;
        int              n;
        it.operation     = 3'($urandom);
        it.device        = 6'($urandom);
        it.start_address = $urandom;
        it.length        = 13'($urandom);
        it.status_byte   = 8'($urandom);
        if ($urandom_range(99) < noise_pct)
            return it;
        case (sb.phase)
            sfts_pkg::PH_IDLE:
            begin
                it.operation = 3'($urandom_range(2, 0));
                if ($urandom_range(99) < 85)
                    for (n = 0; n < 16 && !sb.device_mask[it.device]; n++)
                        it.device = 6'($urandom);
                n = $urandom_range(99);
                it.length = 13'((n < 70) ? $urandom_range(64, 1) :
                                (n < 85) ? $urandom_range(sfts_pkg::MAX_TRANSFER, 1) :
                                (n < 90) ? sfts_pkg::MAX_TRANSFER :
                                (n < 95) ? 0 :
                                $urandom_range(8191, sfts_pkg::MAX_TRANSFER + 1));
                n = (it.operation == sfts_pkg::OP_START_ERASE) ? 1 : int'(it.length);
                lim = {32'd0, sb.device_size};
                if (sb.addr_bytes >= 1 && sb.addr_bytes <= 3 &&
                    lim > (64'd1 << (8 * sb.addr_bytes)))
                    lim = 64'd1 << (8 * sb.addr_bytes);
                if (lim >= 64'(n) && $urandom_range(99) < 85)
                begin
                    span = 32'(lim - 64'(n));
                    it.start_address = ($urandom_range(3) == 0) ?
                        span - $urandom_range((span < 300) ? span : 300, 0) :
                        $urandom_range(span, 0);
                end
            end
            sfts_pkg::PH_POLL:
            begin
                it.operation = sfts_pkg::OP_STATUS;
                it.status_byte[0] = ($urandom_range(99) < busy_pct);
            end
            default: it.operation = sfts_pkg::OP_XFER_DONE;
        endcase
        return it;
    endfunction

    task automatic finish_transfer();
        while (sb.phase != sfts_pkg::PH_IDLE)
            send_item(pick_request(0, 30));
    endtask

    initial
    begin
        int ph;
        int seg;
        int k;
        sb = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // unconfigured after reset
        issue(sfts_pkg::OP_START_READ, 6'd0, 32'd0, 13'd1, 8'd0);
        preset(3'd3, 13'd256, 32'h0100_0000, 64'hFFFF_FFFF_FFFF_FFFE);
        issue(sfts_pkg::OP_START_READ, 6'd0, 32'd0, 13'd16, 8'd0);
        issue(sfts_pkg::OP_START_READ, 6'd63, 32'h00FF_FF00, 13'd256, 8'd0);
        finish_transfer();
        issue(sfts_pkg::OP_START_READ, 6'd1, 32'd0, 13'd0, 8'd0);
        issue(sfts_pkg::OP_START_WRITE, 6'd1, 32'd0, 13'd4097, 8'd0);
        issue(sfts_pkg::OP_START_WRITE, 6'd1, 32'd0, 13'h1FFF, 8'd0);
        issue(sfts_pkg::OP_START_READ, 6'd1, 32'h0100_0000, 13'd1, 8'd0);
        issue(sfts_pkg::OP_START_ERASE, 6'd2, 32'h00FF_FFFF, 13'd0, 8'd0);
        issue(sfts_pkg::OP_XFER_DONE, 6'd0, 32'd0, 13'd0, 8'd0);
        issue(sfts_pkg::OP_XFER_DONE, 6'd0, 32'd0, 13'd0, 8'd0);
        issue(sfts_pkg::OP_STATUS, 6'd0, 32'd0, 13'd0, 8'h01);
        issue(sfts_pkg::OP_STATUS, 6'd0, 32'd0, 13'd0, 8'hFE);
        issue(sfts_pkg::OP_START_ERASE, 6'd2, 32'h0100_0000, 13'd0, 8'd0);
        issue(sfts_pkg::OP_START_WRITE, 6'd5, 32'h0000_00F0, 13'd32, 8'd0);
        // requests and replies that the current phase does not take
        issue(sfts_pkg::OP_START_READ, 6'd5, 32'd0, 13'd8, 8'd0);
        issue(sfts_pkg::OP_STATUS, 6'd5, 32'd0, 13'd0, 8'd0);
        issue(OP_SPARE_A, 6'd0, 32'd0, 13'd0, 8'd0);
        issue(OP_SPARE_B, 6'd21, 32'h5555_5555, 13'h0AAA, 8'h55);
        issue(OP_SPARE_C, 6'd63, 32'hFFFF_FFFF, 13'h1FFF, 8'hFF);
        issue(sfts_pkg::OP_XFER_DONE, 6'd0, 32'd0, 13'd0, 8'd0);
        issue(sfts_pkg::OP_XFER_DONE, 6'd0, 32'd0, 13'd0, 8'd0);
        issue(sfts_pkg::OP_STATUS, 6'd0, 32'd0, 13'd0, 8'h00);
        finish_transfer();

        for (ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 54 : 0;
            recv_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 9 : 0;
            for (seg = 0; seg < 7; seg++)
            begin
                if (seg != 0)
                    retune();
                else if (ph == 0)
                    preset(3'd4, 13'd4096, 32'hFFFF_FFFF, '1);
                else if (ph == 1)
                    preset(3'd1, 13'd1, 32'd256, 64'h8000_0000_0000_0001);
                else
                    preset(3'd2, 13'd16, 32'h0001_0000, 64'h5555_5555_AAAA_AAAA);
                // long output stall while requests keep coming
                if (ph == 0 && seg == 3)
                    hold_left = HOLD_CYCLES;
                for (k = 0; k < 53; k++)
                    send_item(pick_request(12, 40));
            end
        end

        settle();
        repeat (6) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
